FILE: hdl/arot_pkg.sv
// ============================================================================
// arot_pkg: shared types and constants for the address range ownership table
// Holds the field widths, the slot count, the command format passed from the
// front end to the back end, and the back end state encoding.
// ============================================================================
`default_nettype none

package arot_pkg;

  // Number of binding slots held by the table
  localparam int unsigned NUM_BINDINGS = 64;
  localparam int unsigned SLOT_W       = $clog2(NUM_BINDINGS);

  // Fixed field widths
  localparam int unsigned KIND_W       = 1;
  localparam int unsigned BSLOT_W      = 6;
  localparam int unsigned ADDR_W       = 48;
  localparam int unsigned PAGES_W      = 32;
  localparam int unsigned COUNT_W      = 6;

  // 4096-byte pages; a range end never wraps, so it carries one extra bit
  localparam int unsigned PAGE_SHIFT   = 12;
  localparam int unsigned END_W        = ADDR_W + 1;

  // Command queue between front and back end
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W       = QPTR_W + 1;

  // Request kind as it arrives on the input channel
  typedef enum logic [KIND_W-1:0] {
    KIND_CLAIM   = 1'b0,
    KIND_RELEASE = 1'b1
  } kind_e;

  // Classified operation handed to the back end
  typedef enum logic [1:0] {
    OP_CLAIM,
    OP_RELEASE,
    OP_IGNORE
  } cmd_op_e;

  typedef logic [SLOT_W-1:0] slot_idx_t;

  typedef struct packed {
    cmd_op_e               op;
    slot_idx_t             slot;
    logic [ADDR_W-1:0]     start_addr;
    logic [END_W-1:0]      end_addr;
  } cmd_t;

  // One table entry as kept in the range memory
  typedef struct packed {
    logic [ADDR_W-1:0]     start_addr;
    logic [END_W-1:0]      end_addr;
  } range_t;

  localparam int unsigned RANGE_W = $bits(range_t);

  // Back end sequencer
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DRAIN,
    BK_DONE
  } back_state_e;

endpackage

`default_nettype wire

FILE: hdl/arot_if.sv
// ============================================================================
// arot_req_if / arot_rsp_if: valid/ready channels of the ownership table
// The request channel carries one claim or release; the response channel
// carries its result.
// ============================================================================
`default_nettype none

interface arot_req_if;
  logic                         valid;
  logic                         ready;
  logic [arot_pkg::KIND_W-1:0]  kind;
  logic [arot_pkg::BSLOT_W-1:0] binding_slot;
  logic [arot_pkg::ADDR_W-1:0]  range_addr;
  logic [arot_pkg::PAGES_W-1:0] range_pages;

  modport source (output valid, kind, binding_slot, range_addr, range_pages,
                  input ready);
  modport sink   (input valid, kind, binding_slot, range_addr, range_pages,
                  output ready);
endinterface

interface arot_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [arot_pkg::COUNT_W-1:0] superseded_count;
  logic                         still_owned;

  modport source (output valid, superseded_count, still_owned, input ready);
  modport sink   (input valid, superseded_count, still_owned, output ready);
endinterface

`default_nettype wire

FILE: hdl/address_range_ownership_table.sv
// ============================================================================
// address_range_ownership_table: binding slot to address range ownership
// Claims give a slot a new range and retire every other owner it overlaps;
// releases clear a slot and report whether it still owned its range.
//
//  Channel | Dir | Payload                                        | Handshake
//  --------+-----+------------------------------------------------+----------
//  req_i   | in  | kind, binding_slot, range_addr, range_pages    | valid/ready
//  rsp_o   | out | superseded_count, still_owned                  | valid/ready
//
// A claim occupies the back end through its scan, drain and done states: the
// range memory read port sweeps one slot per cycle. A release or an
// out-of-range slot is answered from the idle state. Owned flags are
// flip-flops cleared at reset, so no clearing pass is needed. A two-entry
// command queue keeps taking requests while the back end works or a result waits on rsp_o.
// ============================================================================
`default_nettype none

module address_range_ownership_table (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  arot_req_if.sink  req_i,
  arot_rsp_if.source rsp_o
);

  import arot_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  arot_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  arot_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .rsp_o       (rsp_o)
  );

endmodule

`default_nettype wire

FILE: hdl/arot_ram.sv
// ============================================================================
// arot_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
`default_nettype none

module arot_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hdl/arot_front.sv
// ============================================================================
// arot_front: request intake and classification
// Checks the slot index, works out the end of the claimed range and queues
// the resulting command for the back end in a small FIFO.
// ============================================================================
`default_nettype none

module arot_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  arot_req_if.sink            req_i,
  output logic                cmd_valid_o,
  output arot_pkg::cmd_t      cmd_o,
  input  wire logic           cmd_pop_i
);

  import arot_pkg::*;

  cmd_t              cmd_in;
  logic              slot_ok;
  logic              push;
  cmd_t              queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  // Classify the incoming request
  always_comb begin
    slot_ok           = 32'(req_i.binding_slot) < 32'(NUM_BINDINGS);
    cmd_in.slot       = SLOT_W'(req_i.binding_slot);
    cmd_in.start_addr = req_i.range_addr;
    cmd_in.end_addr   = END_W'(req_i.range_addr)
                      + END_W'({req_i.range_pages, {PAGE_SHIFT{1'b0}}});
    if (!slot_ok) begin
      cmd_in.op = OP_IGNORE;
    end else if (req_i.kind == KIND_RELEASE) begin
      cmd_in.op = OP_RELEASE;
    end else begin
      cmd_in.op = OP_CLAIM;
    end
  end

  assign req_i.ready = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign push        = req_i.valid && req_i.ready;

  // Queue pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (cmd_pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push && !cmd_pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && cmd_pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage, payload only
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_in;
    end
  end

  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];

endmodule

`default_nettype wire

FILE: hdl/arot_back.sv
// ============================================================================
// arot_back: command execution over the binding table
// Keeps the owned flags, writes claimed ranges into the range memory and
// sweeps all slots one per cycle to retire overlapped owners.
// ============================================================================
`default_nettype none

module arot_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cmd_valid_i,
  input  wire arot_pkg::cmd_t cmd_i,
  output logic                cmd_pop_o,
  arot_rsp_if.source          rsp_o
);

  import arot_pkg::*;

  back_state_e          state_q, state_d;
  cmd_t                 cur_q;
  slot_idx_t            idx_q;
  logic                 cmp_vld_q;
  slot_idx_t            cmp_idx_q;
  logic [COUNT_W-1:0]   count_q;
  logic [NUM_BINDINGS-1:0] owned_q;
  logic                 out_valid_q;
  logic [COUNT_W-1:0]   out_count_q;
  logic                 out_owned_q;

  logic                 start;
  logic                 claim_start;
  logic                 scan_rd;
  logic                 last_idx;
  logic                 finish;
  logic                 hit;
  range_t               wr_range;
  range_t               rd_range;
  logic [RANGE_W-1:0]   rd_raw;

  assign last_idx = (idx_q == SLOT_W'(NUM_BINDINGS - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i && !out_valid_q && cmd_i.op == OP_CLAIM) begin
          state_d = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (last_idx) begin
          state_d = BK_DRAIN;
        end
      end
      BK_DRAIN: state_d = BK_DONE;
      BK_DONE:  state_d = BK_IDLE;
      default:  state_d = BK_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    start       = 1'b0;
    scan_rd     = 1'b0;
    finish      = 1'b0;
    unique case (state_q)
      BK_IDLE:  start   = cmd_valid_i && !out_valid_q;
      BK_SCAN:  scan_rd = 1'b1;
      BK_DRAIN: ;
      BK_DONE:  finish  = 1'b1;
      default: ;
    endcase
    claim_start = start && (cmd_i.op == OP_CLAIM);
  end

  assign cmd_pop_o = start;

  // Range memory: claimed range written at start, swept during the scan
  assign wr_range.start_addr = cmd_i.start_addr;
  assign wr_range.end_addr   = cmd_i.end_addr;

  arot_ram #(
    .Width (RANGE_W),
    .Depth (NUM_BINDINGS)
  ) u_range_ram (
    .clk_i   (clk_i),
    .we_i    (claim_start),
    .waddr_i (cmd_i.slot),
    .wdata_i (wr_range),
    .re_i    (scan_rd),
    .raddr_i (idx_q),
    .rdata_o (rd_raw)
  );

  assign rd_range = range_t'(rd_raw);

  // Overlap of an owned other slot with the range being claimed
  assign hit = cmp_vld_q && (cmp_idx_q != cur_q.slot) && owned_q[cmp_idx_q]
            && (END_W'(rd_range.start_addr) < cur_q.end_addr)
            && (END_W'(cur_q.start_addr) < rd_range.end_addr);

  // Sequencer, scan pipeline and owned flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      idx_q     <= '0;
      cmp_vld_q <= 1'b0;
      cmp_idx_q <= '0;
      count_q   <= '0;
      owned_q   <= '0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= scan_rd;
      cmp_idx_q <= idx_q;
      if (claim_start) begin
        idx_q   <= '0;
        count_q <= '0;
      end else if (scan_rd) begin
        idx_q   <= idx_q + 1'b1;
      end
      if (start && cmd_i.op == OP_RELEASE) begin
        owned_q[cmd_i.slot] <= 1'b0;
      end
      if (hit) begin
        owned_q[cmp_idx_q] <= 1'b0;
        count_q            <= count_q + 1'b1;
      end
      if (finish) begin
        owned_q[cur_q.slot] <= 1'b1;
      end
    end
  end

  // Current claim, payload only
  always_ff @(posedge clk_i) begin
    if (claim_start) begin
      cur_q <= cmd_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish || (start && cmd_i.op != OP_CLAIM)) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_count_q <= count_q;
      out_owned_q <= 1'b0;
    end else if (start && cmd_i.op != OP_CLAIM) begin
      out_count_q <= '0;
      out_owned_q <= (cmd_i.op == OP_RELEASE) ? owned_q[cmd_i.slot] : 1'b0;
    end
  end

  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.superseded_count = out_count_q;
  assign rsp_o.still_owned      = out_owned_q;

endmodule

`default_nettype wire

FILE: hdl/arot_checker.sv
// ============================================================================
// arot_checker: port-level checks for the ownership table
// Tracks items in flight and checks the response channel over time.
// ============================================================================
`default_nettype none

module arot_checker (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         req_valid_i,
  input  wire logic                         req_ready_i,
  input  wire logic                         rsp_valid_i,
  input  wire logic                         rsp_ready_i,
  input  wire logic [arot_pkg::COUNT_W-1:0] superseded_count_i,
  input  wire logic                         still_owned_i
);

  import arot_pkg::*;

  logic       req_xfer;
  logic       rsp_xfer;
  logic [2:0] inflight_q, inflight_d;

  assign req_xfer = req_valid_i && req_ready_i;
  assign rsp_xfer = rsp_valid_i && rsp_ready_i;

  // Items accepted but not yet delivered
  always_comb begin
    inflight_d = inflight_q;
    if (req_xfer && !rsp_xfer) begin
      inflight_d = inflight_q + 1'b1;
    end else if (!req_xfer && rsp_xfer) begin
      inflight_d = inflight_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  // A result only shows up for an item that was taken
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> inflight_q != 3'd0)
    else $error("response without an outstanding request");

  // In-flight items never exceed four; queue, back end and result register hold at most three
  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= 3'd4)
    else $error("more items in flight than the datapath can hold");

  // A claim result never reports ownership, a release never counts
  a_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !(still_owned_i && superseded_count_i != '0))
    else $error("result reports both supersede count and ownership");

  // A stalled result keeps its value
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      rsp_valid_i && $stable(superseded_count_i) && $stable(still_owned_i))
    else $error("stalled response changed");

endmodule

bind address_range_ownership_table arot_checker u_arot_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .req_valid_i        (req_i.valid),
  .req_ready_i        (req_i.ready),
  .rsp_valid_i        (rsp_o.valid),
  .rsp_ready_i        (rsp_o.ready),
  .superseded_count_i (rsp_o.superseded_count),
  .still_owned_i      (rsp_o.still_owned)
);

`default_nettype wire

FILE: bench/testbench.sv
// ============================================================================
// testbench: self-checking bench for address_range_ownership_table
// Drives claims and releases over the request channel and checks every
// response against a cycle-free predictor of the slot table. A directed table
// covers the extreme fields and the corner cases. A random run follows, with
// addresses clustered so that overlaps are frequent. Both channels idle at
// random, with one steady stretch in the middle.
// ============================================================================
module testbench;
  import arot_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 7;
  localparam int RANDOM_ITEMS = 1530;
  localparam int IDLE_PCT     = 37;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int DRAIN_CYCLES = 2 * NUM_BINDINGS;
  localparam int NUM_STEPS    = 21;

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [PAGES_W-1:0] pages_t;
  typedef logic [63:0]        wide_t;

  // One claim or release as seen on the request channel
  typedef struct {
    kind_e               kind;
    logic [BSLOT_W-1:0]  slot;
    addr_t               addr;
    pages_t              pages;
  } request_t;

  // One response
  typedef struct {
    logic [COUNT_W-1:0]  superseded;
    logic                still_owned;
  } outcome_t;

  // Directed row; when pinned is set the typed outcome is used as is
  typedef struct packed {
    kind_e               kind;
    logic [BSLOT_W-1:0]  slot;
    addr_t               addr;
    pages_t              pages;
    logic                pinned;
    logic [COUNT_W-1:0]  pin_count;
    logic                pin_owned;
  } step_t;

  logic clk_i;
  logic rst_ni;

  arot_req_if req ();
  arot_rsp_if rsp ();

  address_range_ownership_table dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // Shadow copy of the slot table
  logic   slot_owned [NUM_BINDINGS];
  addr_t  slot_start [NUM_BINDINGS];
  pages_t slot_pages [NUM_BINDINGS];

  outcome_t outcome_q [$];
  int       mismatches;
  logic     steady;

  // Outcome pinned to the request currently on the channel
  logic               pin_now;
  logic [COUNT_W-1:0] pin_count_now;
  logic               pin_owned_now;

  step_t steps [NUM_STEPS];

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Exclusive end of a range; 64 bits so it never wraps past 2^48
  function automatic wide_t range_end(addr_t start, pages_t pages);
    return {16'b0, start} + ({32'b0, pages} << PAGE_SHIFT);
  endfunction

  // Apply one request to the shadow table and return its response
  function automatic outcome_t resolve_ownership(request_t r);
    outcome_t o;
    wide_t    new_end;
    o.superseded = '0;
    o.still_owned = 1'b0;
    if (r.slot < NUM_BINDINGS) begin
      if (r.kind == KIND_CLAIM) begin
        new_end = range_end(r.addr, r.pages);
        slot_owned[r.slot] = 1'b0;
        slot_start[r.slot] = r.addr;
        slot_pages[r.slot] = r.pages;
        for (int i = 0; i < NUM_BINDINGS; i++) begin
          if (slot_owned[i] && {16'b0, slot_start[i]} < new_end &&
              {16'b0, r.addr} < range_end(slot_start[i], slot_pages[i])) begin
            slot_owned[i] = 1'b0;
            o.superseded++;
          end
        end
        slot_owned[r.slot] = 1'b1;
      end else begin
        o.still_owned = slot_owned[r.slot];
        slot_owned[r.slot] = 1'b0;
      end
    end
    return o;
  endfunction

  // Monitor: predict on each request transfer, check each response transfer
  always @(posedge clk_i) begin
    request_t r;
    outcome_t o;
    outcome_t want;
    if (rst_ni) begin
      if (req.valid && req.ready) begin
        r.kind  = kind_e'(req.kind);
        r.slot  = req.binding_slot;
        r.addr  = req.range_addr;
        r.pages = req.range_pages;
        o = resolve_ownership(r);
        if (pin_now) begin
          o.superseded  = pin_count_now;
          o.still_owned = pin_owned_now;
        end
        outcome_q.push_back(o);
      end
      if (rsp.valid && rsp.ready) begin
        if (outcome_q.size() == 0) begin
          $error("response with nothing outstanding: count %0d, owned %0d",
                 rsp.superseded_count, rsp.still_owned);
          mismatches++;
        end else begin
          want = outcome_q.pop_front();
          if (rsp.superseded_count !== want.superseded) begin
            $error("superseded_count: expected %0d, got %0d",
                   want.superseded, rsp.superseded_count);
            mismatches++;
          end
          if (rsp.still_owned !== want.still_owned) begin
            $error("still_owned: expected %0d, got %0d",
                   want.still_owned, rsp.still_owned);
            mismatches++;
          end
        end
      end
    end
  end

  // Response side backpressure
  always @(negedge clk_i) begin
    rsp.ready = steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Present one request and hold it until the transfer
  task automatic send(request_t r, logic pinned, logic [COUNT_W-1:0] pc, logic po);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      req.valid = 1'b0;
      @(negedge clk_i);
    end
    req.valid        = 1'b1;
    req.kind         = r.kind;
    req.binding_slot = r.slot;
    req.range_addr   = r.addr;
    req.range_pages  = r.pages;
    pin_now          = pinned;
    pin_count_now    = pc;
    pin_owned_now    = po;
    do @(posedge clk_i); while (!req.ready);
    @(negedge clk_i);
  endtask

  // Random request; mostly clustered ranges so claims collide often
  function automatic request_t random_request();
    request_t r;
    addr_t    regions [4];
    int       pick;
    regions[0] = 48'h0000_0000_0000;
    regions[1] = 48'h0000_7FFF_0000;
    regions[2] = 48'h8000_0000_0000;
    regions[3] = 48'hFFFF_FFF0_0000;
    r.kind = ($urandom_range(0, 99) < 30) ? KIND_RELEASE : KIND_CLAIM;
    r.slot = BSLOT_W'($urandom_range(0, NUM_BINDINGS - 1));
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      // noise: any address, any length
      r.addr  = ADDR_W'({$urandom, $urandom});
      r.pages = $urandom;
    end else if (pick < 12) begin
      // long ranges near the top end
      r.addr  = regions[3] + ADDR_W'($urandom_range(0, 255) << PAGE_SHIFT);
      r.pages = $urandom_range(0, 32'h00FF_FFFF) << $urandom_range(0, 8);
    end else begin
      r.addr = regions[$urandom_range(0, 3)]
             + ADDR_W'($urandom_range(0, 48) << PAGE_SHIFT);
      if ($urandom_range(0, 3) == 0)
        r.addr += ADDR_W'($urandom_range(0, 4095));
      r.pages = $urandom_range(0, 10);
    end
    return r;
  endfunction

  // Stimulus
  initial begin
    request_t r;
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    req.valid        = 1'b0;
    req.kind         = KIND_CLAIM;
    req.binding_slot = '0;
    req.range_addr   = '0;
    req.range_pages  = '0;
    rsp.ready        = 1'b0;
    pin_now          = 1'b0;
    pin_count_now    = '0;
    pin_owned_now    = 1'b0;
    mismatches       = 0;
    steady           = 1'b0;
    foreach (slot_owned[i]) slot_owned[i] = 1'b0;

    //          kind          slot  addr                pages          pin count owned
    steps = '{
      '{KIND_RELEASE,  6'd0, 48'h0,               32'h0,         1'b1, 6'd0, 1'b0},
      // release ignores extreme address and length
      '{KIND_RELEASE, 6'd63, 48'hFFFF_FFFF_FFFF,  32'hFFFF_FFFF, 1'b1, 6'd0, 1'b0},
      '{KIND_CLAIM,    6'd0, 48'h0,               32'h1,         1'b1, 6'd0, 1'b0},
      // end lands past 2^48 without wrapping
      '{KIND_CLAIM,   6'd63, 48'hFFFF_FFFF_FFFF,  32'hFFFF_FFFF, 1'b1, 6'd0, 1'b0},
      // empty range is still owned
      '{KIND_CLAIM,    6'd1, 48'h1000,            32'h0,         1'b1, 6'd0, 1'b0},
      '{KIND_CLAIM,    6'd2, 48'hFFFF_FFFF_F000,  32'h1,         1'b1, 6'd1, 1'b0},
      // superseded slot no longer owns
      '{KIND_RELEASE, 6'd63, 48'h0,               32'h0,         1'b1, 6'd0, 1'b0},
      '{KIND_RELEASE,  6'd1, 48'h0,               32'h0,         1'b1, 6'd0, 1'b1},
      '{KIND_CLAIM,    6'd3, 48'h0,               32'h2,         1'b1, 6'd1, 1'b0},
      // owner re-claims; its old range is not counted
      '{KIND_CLAIM,    6'd3, 48'h1000,            32'h1,         1'b1, 6'd0, 1'b0},
      '{KIND_CLAIM,   6'd10, 48'h10000,           32'h1,         1'b0, 6'd0, 1'b0},
      '{KIND_CLAIM,   6'd11, 48'h11000,           32'h1,         1'b0, 6'd0, 1'b0},
      '{KIND_CLAIM,   6'd12, 48'h12000,           32'h4,         1'b0, 6'd0, 1'b0},
      // empty range strictly inside an owned one still supersedes it
      '{KIND_CLAIM,   6'd13, 48'h13FFF,           32'h0,         1'b1, 6'd1, 1'b0},
      '{KIND_CLAIM,   6'd14, 48'h10800,           32'h3,         1'b1, 6'd2, 1'b0},
      // touching ranges do not overlap
      '{KIND_CLAIM,   6'd15, 48'h13800,           32'h1,         1'b0, 6'd0, 1'b0},
      '{KIND_RELEASE, 6'd10, 48'h0,               32'h0,         1'b1, 6'd0, 1'b0},
      '{KIND_RELEASE, 6'd14, 48'h0,               32'h0,         1'b0, 6'd0, 1'b0},
      '{KIND_CLAIM,   6'd20, 48'h0,               32'hFFFF_FFFF, 1'b0, 6'd0, 1'b0},
      // empty range at the top address sits inside the last page
      '{KIND_CLAIM,   6'd21, 48'hFFFF_FFFF_FFFF,  32'h0,         1'b1, 6'd1, 1'b0},
      '{KIND_RELEASE, 6'd21, 48'h0,               32'h0,         1'b1, 6'd0, 1'b1}
    };

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed table
    foreach (steps[i]) begin
      r.kind  = steps[i].kind;
      r.slot  = steps[i].slot;
      r.addr  = steps[i].addr;
      r.pages = steps[i].pages;
      send(r, steps[i].pinned, steps[i].pin_count, steps[i].pin_owned);
    end

    // Random run
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 400 && n < 700);
      // hold off once until the table has answered everything
      if (n == 900) begin
        req.valid = 1'b0;
        @(negedge clk_i);
        while (outcome_q.size() != 0) @(negedge clk_i);
      end
      send(random_request(), 1'b0, '0, 1'b0);
    end
    req.valid = 1'b0;
    steady    = 1'b0;

    while (outcome_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (mismatches == 0 && outcome_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(longint'(LIMIT_CYCLES) * CLK_PERIOD);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
